// File: design/mbec_pkg.sv
// shared types and constants of the multiuser bit error counter
`timescale 1ns / 1ps
package mbec_pkg;

	localparam int MAX_USERS_DEF = 16;
	localparam int WORD_BITS_DEF = 64;

	localparam int USER_W    = 4;
	localparam int TOT_W     = 32;
	localparam int NU_W      = 5;
	localparam int BPU_W     = 7;
	localparam int RI_W      = 16;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int WORD_W    = 64;
	localparam int IN_DATA_W  = 2 * WORD_W;
	localparam int OUT_DATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_USERS       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_USER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL = 2'd3;

	localparam logic [NU_W-1:0]  NU_RST  = 5'd1;
	localparam logic [BPU_W-1:0] BPU_RST = 7'd64;
	localparam logic [RI_W-1:0]  RI_RST  = 16'd100;

	typedef struct packed {
		logic accept;
		logic pop;
		logic add;
		logic scan_rd;
		logic close;
		logic emit_rd;
		logic emit_last;
	} cmd_t;

	typedef struct packed {
		logic fend;
	} sts_t;

endpackage

// File: design/mbec_datapath.sv
// datapath: config registers, error count, per-user stores, report and result registers
`timescale 1ns / 1ps
module mbec_datapath #(
	parameter int MAX_USERS = mbec_pkg::MAX_USERS_DEF,
	parameter int WORD_BITS = mbec_pkg::WORD_BITS_DEF,
	parameter int AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1,
	parameter int CW = $clog2(MAX_USERS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mbec_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbec_pkg::CFG_W-1:0]        cfg_data,
	input  logic [mbec_pkg::USER_W-1:0]       in_user,
	input  logic [mbec_pkg::WORD_W-1:0]       in_ref,
	input  logic [mbec_pkg::WORD_W-1:0]       in_rx,
	input  logic                              in_fend,
	input  mbec_pkg::cmd_t                    cmd,
	input  logic [AW-1:0]                     idx,
	output mbec_pkg::sts_t                    sts,
	output logic [CW-1:0]                     n_eff,
	output logic [mbec_pkg::USER_W-1:0]       out_user,
	output logic [mbec_pkg::TOT_W-1:0]        out_errors,
	output logic                              out_stop,
	output logic                              out_last
);
	import mbec_pkg::*;

	localparam int NL = (WORD_BITS + 7) / 8;
	localparam int PW = $clog2(NL * 8 + 1);

	logic [NU_W-1:0]  nu_q;
	logic [BPU_W-1:0] bpu_q;
	logic [TOT_W-1:0] max_q;
	logic [RI_W-1:0]  ri_q;
	logic [RI_W-1:0]  frm_q;
	logic             below_q;
	logic             stop_q;

	logic [TOT_W-1:0] tot_mem [MAX_USERS];
	logic [TOT_W-1:0] rep_mem [MAX_USERS];
	logic [TOT_W-1:0] int_mem [MAX_USERS];
	logic [MAX_USERS-1:0] tot_v_q;
	logic [MAX_USERS-1:0] rep_v_q;
	logic [MAX_USERS-1:0] int_v_q;

	logic [NL*8-1:0]  diff;
	logic [NL*8-1:0]  diff_s1;
	logic [AW-1:0]    user_s1;
	logic             upd_s1;
	logic             fend_s1;
	logic [3:0]       lane_s2 [NL];
	logic [3:0]       lane_cnt [NL];
	logic [PW-1:0]    sum;
	logic [BPU_W-1:0] bits_sat;

	logic [AW-1:0]    tot_raddr;
	logic             tot_ren;
	logic [TOT_W-1:0] tot_rd_q;
	logic             tot_rv_q;
	logic [TOT_W-1:0] rep_rd_q;
	logic             rep_rv_q;
	logic [TOT_W-1:0] int_rd_q;
	logic             int_rv_q;
	logic [TOT_W-1:0] tot_val;
	logic [TOT_W-1:0] rep_val;

	logic             scan_v_s1;
	logic [AW-1:0]    scan_idx_s1;
	logic             hit;
	logic             rep_we;
	logic             tot_we;
	logic [USER_W-1:0] out_user_q;
	logic             out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nu_q  <= NU_RST;
			bpu_q <= BPU_RST;
			max_q <= '0;
			ri_q  <= RI_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_USERS:       nu_q  <= cfg_data[NU_W-1:0];
				REG_BITS_PER_USER:   bpu_q <= cfg_data[BPU_W-1:0];
				REG_MAX_ERRORS:      max_q <= cfg_data[TOT_W-1:0];
				REG_REPORT_INTERVAL: ri_q  <= cfg_data[RI_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (nu_q == '0) begin
			n_eff = CW'(1);
		end else if (32'(nu_q) > MAX_USERS) begin
			n_eff = CW'(MAX_USERS);
		end else begin
			n_eff = CW'(nu_q);
		end
		if (32'(bpu_q) > WORD_BITS) begin
			bits_sat = BPU_W'(WORD_BITS);
		end else begin
			bits_sat = bpu_q;
		end
	end

	// masked difference of the compared bits
	always_comb begin
		diff = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			diff[j] = (in_ref[j] ^ in_rx[j]) & (BPU_W'(j) < bits_sat);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1  <= 1'b0;
			fend_s1 <= 1'b0;
		end else if (cmd.accept) begin
			upd_s1  <= ({28'd0, in_user} < 32'(MAX_USERS));
			fend_s1 <= in_fend;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			diff_s1 <= diff;
			user_s1 <= AW'(in_user);
		end
	end

	assign sts.fend = fend_s1;

	// per-byte ones count, then lane sum
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			lane_cnt[l] = '0;
			for (int b = 0; b < 8; b++) begin
				lane_cnt[l] = lane_cnt[l] + 4'(diff_s1[l*8+b]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			for (int l = 0; l < NL; l++) begin
				lane_s2[l] <= lane_cnt[l];
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int l = 0; l < NL; l++) begin
			sum = sum + PW'(lane_s2[l]);
		end
	end

	// error total store
	assign tot_ren   = cmd.accept | cmd.scan_rd;
	assign tot_raddr = cmd.accept ? AW'(in_user) : idx;
	assign tot_val   = tot_rv_q ? tot_rd_q : '0;
	assign rep_val   = rep_rv_q ? rep_rd_q : '0;
	assign tot_we    = cmd.add & upd_s1;
	assign hit       = (frm_q == ri_q);
	assign rep_we    = scan_v_s1 & hit;

	always_ff @(posedge clk) begin
		if (tot_ren) begin
			tot_rd_q <= tot_mem[tot_raddr];
		end
		if (tot_we) begin
			tot_mem[user_s1] <= tot_val + TOT_W'(sum);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			rep_rd_q <= rep_mem[idx];
		end
		if (rep_we) begin
			rep_mem[scan_idx_s1] <= tot_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_rd) begin
			int_rd_q <= int_mem[idx];
		end
		if (rep_we) begin
			int_mem[scan_idx_s1] <= tot_val - rep_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_v_q  <= '0;
			rep_v_q  <= '0;
			int_v_q  <= '0;
			tot_rv_q <= 1'b0;
			rep_rv_q <= 1'b0;
			int_rv_q <= 1'b0;
		end else begin
			if (tot_ren) begin
				tot_rv_q <= tot_v_q[tot_raddr];
			end
			if (cmd.scan_rd) begin
				rep_rv_q <= rep_v_q[idx];
			end
			if (cmd.emit_rd) begin
				int_rv_q <= int_v_q[idx];
			end
			if (tot_we) begin
				tot_v_q[user_s1] <= 1'b1;
			end
			if (rep_we) begin
				rep_v_q[scan_idx_s1] <= 1'b1;
				int_v_q[scan_idx_s1] <= 1'b1;
			end
		end
	end

	// frame close: stop check, report refresh, frame counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1 <= 1'b0;
			below_q   <= 1'b0;
			stop_q    <= 1'b0;
			frm_q     <= '0;
		end else begin
			scan_v_s1 <= cmd.scan_rd;
			if (cmd.add) begin
				below_q <= 1'b0;
			end else if (scan_v_s1 && (CW'(scan_idx_s1) < n_eff) && (tot_val < max_q)) begin
				below_q <= 1'b1;
			end
			if (cmd.close) begin
				stop_q <= (max_q != '0) & ~below_q;
				frm_q  <= hit ? RI_W'(1) : frm_q + RI_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			scan_idx_s1 <= idx;
		end
		if (cmd.emit_rd) begin
			out_user_q <= USER_W'(idx);
			out_last_q <= cmd.emit_last;
		end
	end

	assign out_user   = out_user_q;
	assign out_errors = int_rv_q ? int_rd_q : '0;
	assign out_stop   = stop_q;
	assign out_last   = out_last_q;

endmodule

// File: design/mbec_ctrl.sv
// controller: item sequencing, frame close scan and result emission
`timescale 1ns / 1ps
module mbec_ctrl #(
	parameter int MAX_USERS = mbec_pkg::MAX_USERS_DEF,
	parameter int AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1,
	parameter int CW = $clog2(MAX_USERS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  mbec_pkg::sts_t  sts,
	input  logic [CW-1:0]   n_eff,
	output mbec_pkg::cmd_t  cmd,
	output logic [AW-1:0]   idx
);
	import mbec_pkg::*;

	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_USERS - 1);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_POP      = 8'b0000_0010,
		S_ADD      = 8'b0000_0100,
		S_SCAN     = 8'b0000_1000,
		S_DRAIN    = 8'b0001_0000,
		S_CLOSE    = 8'b0010_0000,
		S_EMIT_RD  = 8'b0100_0000,
		S_EMIT_OUT = 8'b1000_0000
	} state_t;

	state_t        state_q;
	state_t        state_d;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] cnt_d;
	logic          emit_last;

	assign emit_last = (CW'(cnt_q) == n_eff - CW'(1));
	assign idx       = cnt_q;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = S_POP;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				cnt_d   = '0;
				state_d = sts.fend ? S_SCAN : S_IDLE;
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (cnt_q == LAST_IDX) begin
					state_d = S_DRAIN;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			S_DRAIN: begin
				state_d = S_CLOSE;
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				cnt_d     = '0;
				state_d   = S_EMIT_RD;
			end
			S_EMIT_RD: begin
				cmd.emit_rd   = 1'b1;
				cmd.emit_last = emit_last;
				state_d       = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (emit_last) begin
						state_d = S_IDLE;
					end else begin
						cnt_d   = cnt_q + AW'(1);
						state_d = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_accept_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_POP))
		else $error("accepted beat not followed by count stage");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && emit_last) |=> (state_q == S_IDLE && in_ready))
		else $error("final result not followed by idle");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CW'(cnt_q) < n_eff))
		else $error("result index beyond active users");

endmodule

// File: design/multiuser_bit_error_counter.sv
// top level of the multiuser bit error counter
//
// Input stream (s_axis): one beat per user word, tuser = user index, tdata = reference
// word (bits 63:0) and received word (bits 127:64), tlast = end of frame.
// Output stream (m_axis): one beat per active user after each frame end, tuser = user
// index, tdata = interval error count (31:0) and stop flag (32), tlast on the final user.
// Config port: cfg_we writes cfg_data into register cfg_index (0 num_users, 1 bits_per_user,
// 2 max_errors, 3 report_interval); write only while the block is idle.
// Each input beat passes a word compare, a per-byte ones count and an add into the
// single-port per-user total store. A frame end adds a close pass that walks the
// MAX_USERS entries of the stores one per cycle, then a drain step and a close step;
// each result then takes a store read and an output beat, and waits on any receiver
// stall. s_axis_tready is low from an accepted beat until its work and any result burst
// are done. A stalled result holds m_axis_tdata, tuser and tlast until taken. Reset
// clears all totals, snapshots, interval counts, the frame counter and the stop flag,
// and loads the register defaults.
`timescale 1ns / 1ps
module multiuser_bit_error_counter #(
	parameter int MAX_USERS = mbec_pkg::MAX_USERS_DEF,
	parameter int WORD_BITS = mbec_pkg::WORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [mbec_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // ref_word, rx_word
	input  logic [mbec_pkg::USER_W-1:0]       s_axis_tuser,  // user
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [mbec_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // interval_errors, stop, zero pad
	output logic [mbec_pkg::USER_W-1:0]       m_axis_tuser,  // out_user
	output logic                              m_axis_tlast,
	input  logic                              cfg_we,
	input  logic [mbec_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbec_pkg::CFG_W-1:0]        cfg_data
);
	import mbec_pkg::*;

	localparam int AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
	localparam int CW = $clog2(MAX_USERS + 1);

	cmd_t             cmd;
	sts_t             sts;
	logic [AW-1:0]    idx;
	logic [CW-1:0]    n_eff;
	logic [TOT_W-1:0] out_errors;
	logic             out_stop;

	mbec_ctrl #(
		.MAX_USERS (MAX_USERS),
		.AW        (AW),
		.CW        (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.n_eff     (n_eff),
		.cmd       (cmd),
		.idx       (idx)
	);

	mbec_datapath #(
		.MAX_USERS (MAX_USERS),
		.WORD_BITS (WORD_BITS),
		.AW        (AW),
		.CW        (CW)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_user    (s_axis_tuser),
		.in_ref     (s_axis_tdata[WORD_W-1:0]),
		.in_rx      (s_axis_tdata[IN_DATA_W-1:WORD_W]),
		.in_fend    (s_axis_tlast),
		.cmd        (cmd),
		.idx        (idx),
		.sts        (sts),
		.n_eff      (n_eff),
		.out_user   (m_axis_tuser),
		.out_errors (out_errors),
		.out_stop   (out_stop),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {(OUT_DATA_W - TOT_W - 1)'(0), out_stop, out_errors};

endmodule

// File: sim/tb.sv
// self-checking testbench for the multiuser bit error counter stream block
`timescale 1ns / 1ps
module tb;
	import mbec_pkg::*;

	localparam int LIMIT = 400000;
	localparam int USERS = MAX_USERS_DEF;
	localparam int WORD_TARGET = 92;

	typedef struct packed {
		logic [USER_W-1:0] user;
		logic [TOT_W-1:0]  errs;
		logic              stop;
		logic              last;
	} count_beat_t;

	class error_tally;
		logic [NU_W-1:0]  num_users;
		logic [BPU_W-1:0] bits_per_user;
		logic [TOT_W-1:0] max_errors;
		logic [RI_W-1:0]  report_interval;
		logic [TOT_W-1:0] totals [USERS];
		logic [TOT_W-1:0] at_report [USERS];
		logic [TOT_W-1:0] held [USERS];
		logic [RI_W-1:0]  frames;
		logic             stop_flag;
		count_beat_t      pending_counts [$];
		int               fails;

		function new();
			num_users = NU_RST;
			bits_per_user = BPU_RST;
			max_errors = '0;
			report_interval = RI_RST;
			foreach (totals[i]) begin
				totals[i] = '0;
				at_report[i] = '0;
				held[i] = '0;
			end
			frames = '0;
			stop_flag = 1'b0;
			fails = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
			REG_NUM_USERS: num_users = val[NU_W-1:0];
			REG_BITS_PER_USER: bits_per_user = val[BPU_W-1:0];
			REG_MAX_ERRORS: max_errors = val[TOT_W-1:0];
			REG_REPORT_INTERVAL: report_interval = val[RI_W-1:0];
			default: ;
			endcase
		endfunction

		function int active();
			if (num_users == 0)
				return 1;
			if (num_users > USERS)
				return USERS;
			return num_users;
		endfunction

		function void add_word(logic [USER_W-1:0] user, logic [WORD_W-1:0] ref_w,
			logic [WORD_W-1:0] rx_w, logic fend);
			logic [WORD_W-1:0] mask;
			int bits;
			int n;
			int i;
			logic below;
			count_beat_t b;
			bits = (bits_per_user > WORD_W) ? WORD_W : bits_per_user;
			mask = (bits >= WORD_W) ? '1 : ((64'd1 << bits) - 64'd1);
			totals[user] = totals[user] + $countones((ref_w ^ rx_w) & mask);
			if (!fend)
				return;
			n = active();
			below = 1'b0;
			for (i = 0; i < n; i++)
				if (totals[i] < max_errors)
					below = 1'b1;
			stop_flag = (max_errors != 0) && !below;
			if (frames == report_interval) begin
				for (i = 0; i < USERS; i++) begin
					held[i] = totals[i] - at_report[i];
					at_report[i] = totals[i];
				end
				frames = '0;
			end
			frames = frames + 1'b1;
			for (i = 0; i < n; i++) begin
				b.user = i[USER_W-1:0];
				b.errs = held[i];
				b.stop = stop_flag;
				b.last = (i == n - 1);
				pending_counts.push_back(b);
			end
		endfunction

		task report_mismatch(string what, logic [TOT_W-1:0] got, logic [TOT_W-1:0] want);
			if (fails < 40)
				$display("mismatch: %s got %0h want %0h at %0t ns", what, got, want, $time);
			fails++;
		endtask

		task check_count(count_beat_t got);
			count_beat_t want;
			if (pending_counts.size() == 0) begin
				report_mismatch("result beat with nothing pending, user", TOT_W'(got.user),
					'0);
				return;
			end
			want = pending_counts.pop_front();
			if (got.user != want.user)
				report_mismatch("out_user", TOT_W'(got.user), TOT_W'(want.user));
			if (got.errs != want.errs)
				report_mismatch("interval_errors", got.errs, want.errs);
			if (got.stop != want.stop)
				report_mismatch("stop", TOT_W'(got.stop), TOT_W'(want.stop));
			if (got.last != want.last)
				report_mismatch("last", TOT_W'(got.last), TOT_W'(want.last));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [USER_W-1:0]     s_axis_tuser = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [USER_W-1:0]     m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;

	error_tally tally = new();
	logic       calm = 1'b0;
	int         words_sent = 0;
	int         cycles = 0;

	multiuser_bit_error_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready = calm || ($urandom_range(99) >= 7);
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			tally.add_word(s_axis_tuser, s_axis_tdata[WORD_W-1:0],
				s_axis_tdata[IN_DATA_W-1:WORD_W], s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tally.check_count({m_axis_tuser, m_axis_tdata[TOT_W-1:0], m_axis_tdata[TOT_W],
				m_axis_tlast});
	end

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [WORD_W-1:0] flip_mask();
		case ($urandom_range(4))
		0: return '0;
		1: return '1;
		2: return 64'd1 << $urandom_range(63);
		3: return rand_word() & rand_word();
		default: return rand_word();
		endcase
	endfunction

	task automatic send_word(logic [USER_W-1:0] user, logic [WORD_W-1:0] ref_w,
		logic [WORD_W-1:0] rx_w, logic fend);
		if (!calm && $urandom_range(99) < 7)
			repeat ($urandom_range(1, 4)) @(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {rx_w, ref_w};
		s_axis_tuser = user;
		s_axis_tlast = fend;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		words_sent++;
	endtask

	task automatic send_frame(int n);
		logic [WORD_W-1:0] w;
		for (int u = 0; u < n; u++) begin
			w = rand_word();
			send_word(u[USER_W-1:0], w, w ^ flip_mask(), u == n - 1);
		end
	endtask

	task automatic drain();
		while (tally.pending_counts.size() != 0) @(negedge clk);
	endtask

	// block idle: no results pending, input side free, last word's pipeline flushed
	task automatic settle();
		drain();
		while (!s_axis_tready) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		tally.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_config();
		logic [CFG_W-1:0] v;
		case ($urandom_range(9))
		0: v = 0;
		1: v = $urandom_range(17, 31);
		default: v = $urandom_range(1, 16);
		endcase
		write_reg(REG_NUM_USERS, v);
		case ($urandom_range(7))
		0: v = 0;
		1: v = $urandom_range(65, 127);
		2: v = 64;
		default: v = $urandom_range(1, 63);
		endcase
		write_reg(REG_BITS_PER_USER, v);
		case ($urandom_range(5))
		0: v = 0;
		1: v = '1;
		2: v = 1;
		default: v = $urandom_range(2, 600);
		endcase
		write_reg(REG_MAX_ERRORS, v);
		// the refresh only fires on an exact match, so aim just ahead of the frame count
		if ($urandom_range(5) == 0)
			v = $urandom_range(0, 65535);
		else
			v = (tally.frames + $urandom_range(0, 4)) & 32'hFFFF;
		write_reg(REG_REPORT_INTERVAL, v);
	endtask

	initial begin
		int phase;
		int target;
		int count;
		logic [WORD_W-1:0] w;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		settle();

		// zero users, oversized bit count, stop target of one, interval of zero
		write_reg(REG_NUM_USERS, 0);
		write_reg(REG_BITS_PER_USER, 127);
		write_reg(REG_MAX_ERRORS, 1);
		write_reg(REG_REPORT_INTERVAL, 0);
		send_word(0, '0, '1, 1'b1);
		send_word(0, '1, '1, 1'b1);
		send_word(15, '1, '0, 1'b0);
		send_word(0, {32{2'b01}}, {32{2'b10}}, 1'b1);
		settle();

		// oversized user count, nothing compared, frame count is now 3
		write_reg(REG_NUM_USERS, 31);
		write_reg(REG_BITS_PER_USER, 0);
		write_reg(REG_MAX_ERRORS, '1);
		write_reg(REG_REPORT_INTERVAL, 3);
		for (int u = 0; u < USERS; u++)
			send_word(u[USER_W-1:0], rand_word(), rand_word(), u == USERS - 1);
		settle();

		write_reg(REG_NUM_USERS, 16);
		write_reg(REG_BITS_PER_USER, 1);
		write_reg(REG_MAX_ERRORS, 0);
		write_reg(REG_REPORT_INTERVAL, 16'hFFFF);
		send_word(0, 64'd1, 64'd0, 1'b0);
		send_word(3, '1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
		send_word(7, '0, '1, 1'b0);
		send_word(15, '0, '1, 1'b1);
		settle();

		phase = 0;
		while (words_sent < WORD_TARGET) begin
			random_config();
			calm = (phase == 0);
			target = $urandom_range(15, 30);
			count = 0;
			while (count < target) begin
				if ($urandom_range(4) != 0) begin
					send_frame(tally.active());
					count += tally.active();
				end else begin
					repeat ($urandom_range(1, 5)) begin
						w = rand_word();
						send_word(USER_W'($urandom_range(15)), w, w ^ flip_mask(),
							$urandom_range(2) == 0);
						count++;
					end
				end
				if (phase == 1 || $urandom_range(5) == 0)
					drain();
			end
			settle();
			calm = 1'b0;
			phase++;
		end

		drain();
		repeat (60) @(posedge clk);
		if (tally.fails == 0 && tally.pending_counts.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: multiuser_bit_error_counter.f
design/mbec_pkg.sv
design/mbec_datapath.sv
design/mbec_ctrl.sv
design/multiuser_bit_error_counter.sv
sim/tb.sv
